FILE: hdl/bss_pkg.sv
// Shared types and constants for the burst sample statistics unit.
// No dependencies; imported by every module of the block.
package bss_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned TAG_W       = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  // What the front tells the back about each accepted item
  typedef enum logic [1:0] {
    KIND_TAG,
    KIND_SAMPLE,
    KIND_LAST
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e         kind;
    logic [SAMPLE_W-1:0] value;
    logic [TAG_W-1:0]    tag;
  } queue_entry_t;

endpackage

FILE: hdl/bss_front.sv
// Front end: accepts input items, tracks the position within a burst and
// classifies each item for the back end. Depends on bss_pkg.
module bss_front #(
  parameter int unsigned BURST = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bss_pkg::SAMPLE_W-1:0]  conversion_i,
  input  logic [bss_pkg::TAG_W-1:0]     channel_tag_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output bss_pkg::queue_entry_t         q_entry_o
);
  import bss_pkg::*;

  localparam int unsigned CW = $clog2(BURST + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    cnt_d           = cnt_q;
    q_entry_o.value = conversion_i;
    q_entry_o.tag   = channel_tag_i;
    q_entry_o.kind  = KIND_SAMPLE;
    if (cnt_q == '0) begin
      // first item of a burst only carries the channel tag
      q_entry_o.kind = KIND_TAG;
    end else if (cnt_q == CW'(BURST)) begin
      q_entry_o.kind = KIND_LAST;
    end
    if (accept) begin
      if (cnt_q == CW'(BURST)) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/bss_queue.sv
// Short FIFO between the front end and the back end.
// Depends on bss_pkg for the entry type and depth.
module bss_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bss_pkg::queue_entry_t entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output bss_pkg::queue_entry_t entry_o
);
  import bss_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     slots_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == NW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

endmodule

FILE: hdl/bss_back.sv
// Back end: insertion sort into a single-port-read store, running sum,
// burst read-out, mean by reciprocal multiply and the result register.
// Depends on bss_pkg.
module bss_back #(
  parameter int unsigned BURST = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bss_pkg::queue_entry_t         q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bss_pkg::SAMPLE_W-1:0]  smallest_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  largest_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  average_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  middle_o,
  output logic [bss_pkg::TAG_W-1:0]     channel_out_o
);
  import bss_pkg::*;

  localparam int unsigned AW     = (BURST > 1) ? $clog2(BURST) : 1;
  localparam int unsigned SW     = $clog2(BURST * ((1 << SAMPLE_W) - 1) + 1);
  // Round-up reciprocal: exact quotient for every sum below 2**SW
  localparam int unsigned K      = SW + $clog2(BURST);
  localparam int unsigned RECIP  = ((1 << K) + BURST - 1) / BURST;
  localparam int unsigned PW     = SW + K;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_RD0   = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_RD2   = 3'd5;
  localparam logic [2:0] S_RD3   = 3'd6;
  localparam logic [2:0] S_RD4   = 3'd7;
  localparam logic [2:0] S_EMIT  = S_IDLE;

  logic [SAMPLE_W-1:0] mem [BURST];
  logic [SAMPLE_W-1:0] rd_q;
  logic                we;
  logic [AW-1:0]       wa, ra;
  logic [SAMPLE_W-1:0] wd;

  logic [2:0]          state_q, state_d;
  logic                emit_q, emit_d;
  logic [AW-1:0]       filled_q, filled_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [SAMPLE_W-1:0] val_q, val_d;
  logic                last_q, last_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [TAG_W-1:0]    chan_q, chan_d;
  logic [SAMPLE_W-1:0] min_q, min_d, max_q, max_d, lo_q, lo_d, hi_q, hi_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic                ins_done;
  logic [SAMPLE_W:0]   mid_sum;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] smallest_q, largest_q, average_q, middle_q;
  logic [TAG_W-1:0]    channel_q;
  logic                load_out;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    state_d     = state_q;
    emit_d      = emit_q;
    filled_d    = filled_q;
    slot_d      = slot_q;
    val_d       = val_q;
    last_d      = last_q;
    sum_d       = sum_q;
    chan_d      = chan_q;
    min_d       = min_q;
    max_d       = max_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    prod_d      = prod_q;
    we          = 1'b0;
    wa          = '0;
    wd          = val_q;
    ra          = '0;
    q_pop_o     = 1'b0;
    ins_done    = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    if (emit_q) begin
      // hold the finished burst until the result register frees up
      if (!out_valid_q || !out_stall_i) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
        emit_d      = 1'b0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            case (q_entry_i.kind)
              KIND_TAG: begin
                chan_d = q_entry_i.tag;
              end
              KIND_SAMPLE, KIND_LAST: begin
                val_d  = q_entry_i.value;
                last_d = (q_entry_i.kind == KIND_LAST);
                sum_d  = sum_q + SW'(q_entry_i.value);
                if (filled_q == '0) begin
                  we       = 1'b1;
                  wa       = '0;
                  wd       = q_entry_i.value;
                  ins_done = 1'b1;
                end else begin
                  ra      = filled_q - AW'(1);
                  slot_d  = filled_q;
                  state_d = S_WALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          // rd_q holds the entry just below the hole
          if (rd_q > val_q) begin
            we     = 1'b1;
            wa     = slot_q;
            wd     = rd_q;
            slot_d = slot_q - AW'(1);
            if (slot_q == AW'(1)) begin
              state_d = S_PLACE;
            end else begin
              ra = slot_q - AW'(1) - AW'(1);
            end
          end else begin
            we       = 1'b1;
            wa       = slot_q;
            wd       = val_q;
            ins_done = 1'b1;
          end
        end
        S_PLACE: begin
          we       = 1'b1;
          wa       = slot_q;
          wd       = val_q;
          ins_done = 1'b1;
        end
        S_RD0: begin
          ra      = '0;
          state_d = S_RD1;
        end
        S_RD1: begin
          min_d   = rd_q;
          ra      = AW'(BURST - 1);
          state_d = S_RD2;
        end
        S_RD2: begin
          max_d   = rd_q;
          ra      = AW'(BURST / 2 - 1);
          state_d = S_RD3;
        end
        S_RD3: begin
          lo_d    = rd_q;
          ra      = AW'(BURST / 2);
          state_d = S_RD4;
        end
        S_RD4: begin
          hi_d    = rd_q;
          prod_d  = PW'(sum_q) * PW'(RECIP);
          sum_d   = '0;
          emit_d  = 1'b1;
          state_d = S_EMIT;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase

      if (ins_done) begin
        if (last_d) begin
          filled_d = '0;
          state_d  = S_RD0;
        end else begin
          filled_d = filled_q + AW'(1);
          state_d  = S_IDLE;
        end
      end
    end
  end

  // sorted store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    val_q  <= val_d;
    min_q  <= min_d;
    max_q  <= max_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    prod_q <= prod_d;
    if (load_out) begin
      smallest_q <= min_q;
      largest_q  <= max_q;
      average_q  <= prod_q[K +: SAMPLE_W];
      middle_q   <= mid_sum[SAMPLE_W:1];
      channel_q  <= chan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_q      <= 1'b0;
      filled_q    <= '0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      filled_q    <= filled_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign smallest_o    = smallest_q;
  assign largest_o     = largest_q;
  assign average_o     = average_q;
  assign middle_o      = middle_q;
  assign channel_out_o = channel_q;

endmodule

FILE: hdl/burst_sample_statistics_unit.sv
// Top level of the burst sample statistics unit.
// Instantiates bss_front, bss_queue and bss_back; depends on bss_pkg.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o | conversion_i, channel_tag_i
//   out     | out_valid_o / out_stall_i | smallest_o, largest_o, average_o,
//           |                        | middle_o, channel_out_o
//
// The front takes one item a cycle while the two-entry queue has room.
// The back takes a tag item or the first counted sample of a burst straight
// from idle; each later sample walks the store and shifts s store slots (at
// most BURST-1) one at a time, as the store has a single read port.
// A burst end adds read-out (S_RD0 to S_RD4) and mean calculation before the
// result is registered.
// Reset clears control state; the sorted store is not cleared.
// The result register holds under out_stall_i; the front meanwhile fills the queue until it is full.
module burst_sample_statistics_unit #(
  parameter int unsigned BURST = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bss_pkg::SAMPLE_W-1:0]  conversion_i,
  input  logic [bss_pkg::TAG_W-1:0]     channel_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bss_pkg::SAMPLE_W-1:0]  smallest_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  largest_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  average_o,
  output logic [bss_pkg::SAMPLE_W-1:0]  middle_o,
  output logic [bss_pkg::TAG_W-1:0]     channel_out_o
);
  import bss_pkg::*;

  logic         q_push, q_full, q_valid, q_pop;
  queue_entry_t q_wr_entry, q_rd_entry;

  bss_front #(
    .BURST(BURST)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .conversion_i (conversion_i),
    .channel_tag_i(channel_tag_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_wr_entry)
  );

  bss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_wr_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .entry_o(q_rd_entry)
  );

  bss_back #(
    .BURST(BURST)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .smallest_o   (smallest_o),
    .largest_o    (largest_o),
    .average_o    (average_o),
    .middle_o     (middle_o),
    .channel_out_o(channel_out_o)
  );

endmodule

FILE: hdl/bss_checker.sv
// Port-level checks for the burst sample statistics unit, bound to the top.
// Depends on bss_pkg for field widths.
module bss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bss_pkg::SAMPLE_W-1:0]  smallest_o,
  input logic [bss_pkg::SAMPLE_W-1:0]  largest_o,
  input logic [bss_pkg::SAMPLE_W-1:0]  average_o,
  input logic [bss_pkg::SAMPLE_W-1:0]  middle_o,
  input logic [bss_pkg::TAG_W-1:0]     channel_out_o
);
  import bss_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smallest_o) &&
      $stable(largest_o) && $stable(average_o) && $stable(middle_o) &&
      $stable(channel_out_o))
    else $error("stalled result changed");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> smallest_o <= largest_o)
    else $error("minimum above maximum");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> smallest_o <= average_o && average_o <= largest_o)
    else $error("mean outside sample range");

  a_mid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> smallest_o <= middle_o && middle_o <= largest_o)
    else $error("middle outside sample range");

endmodule

bind burst_sample_statistics_unit bss_checker u_bss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .smallest_o   (smallest_o),
  .largest_o    (largest_o),
  .average_o    (average_o),
  .middle_o     (middle_o),
  .channel_out_o(channel_out_o)
);

FILE: bench/testbench.sv
// Self-checking bench for burst_sample_statistics_unit: drives bursts of
// ADC conversions, predicts min, max, mean and median per burst and compares.
// Depends on bss_pkg and the RTL of the unit; stands alone otherwise.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int unsigned BURST     = 16;
  localparam int unsigned LONG_HOLD = 600;

  typedef struct packed {
    logic [SAMPLE_W-1:0] conversion;
    logic [TAG_W-1:0]    tag;
  } adc_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smallest;
    logic [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] middle;
    logic [TAG_W-1:0]    channel;
  } burst_stats_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_CLUSTER,
    PAT_RISING,
    PAT_FALLING,
    PAT_FLAT,
    PAT_RAILS,
    PAT_REPEATS
  } burst_shape_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] conversion_i  = '0;
  logic [TAG_W-1:0]    channel_tag_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [SAMPLE_W-1:0] smallest_o;
  logic [SAMPLE_W-1:0] largest_o;
  logic [SAMPLE_W-1:0] average_o;
  logic [SAMPLE_W-1:0] middle_o;
  logic [TAG_W-1:0]    channel_out_o;

  adc_item_t    pending_items[$];
  burst_stats_t stats_due[$];

  // Predictor state
  logic [SAMPLE_W-1:0] ranked[BURST];
  int unsigned         sum_acc;
  int unsigned         taken_cnt;
  logic [TAG_W-1:0]    burst_tag;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  logic        in_taken     = 1'b0;
  logic        calm         = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_gap    = 0;
  int unsigned long_left    = 0;
  logic        long_done    = 1'b0;

  burst_sample_statistics_unit #(.BURST(BURST)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .conversion_i  (conversion_i),
    .channel_tag_i (channel_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .smallest_o    (smallest_o),
    .largest_o     (largest_o),
    .average_o     (average_o),
    .middle_o      (middle_o),
    .channel_out_o (channel_out_o)
  );

  always #4 clk_i = ~clk_i;

  // Fold one accepted conversion into the burst statistics
  task automatic fold_sample(input logic [SAMPLE_W-1:0] value,
                             input logic [TAG_W-1:0] tag);
    int unsigned  slot;
    burst_stats_t stats;
    if (taken_cnt == 0) begin
      // the settling sample only supplies the channel
      burst_tag = tag;
      taken_cnt = 1;
      return;
    end
    slot = taken_cnt - 1;
    while (slot > 0 && ranked[slot-1] > value) begin
      ranked[slot] = ranked[slot-1];
      slot--;
    end
    ranked[slot] = value;
    sum_acc += value;
    taken_cnt++;
    if (taken_cnt > BURST) begin
      stats.smallest = ranked[0];
      stats.largest  = ranked[BURST-1];
      stats.average  = SAMPLE_W'(sum_acc / BURST);
      stats.middle   = SAMPLE_W'((int'(ranked[BURST/2-1]) + int'(ranked[BURST/2])) / 2);
      stats.channel  = burst_tag;
      stats_due.push_back(stats);
      sum_acc   = 0;
      taken_cnt = 0;
    end
  endtask

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  task automatic queue_burst(input burst_shape_e shape);
    adc_item_t           item;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] stride;
    base   = SAMPLE_W'($urandom_range(0, 4095));
    stride = SAMPLE_W'($urandom_range(0, 300));
    if (shape == PAT_FLAT && $urandom_range(0, 2) == 0)
      base = $urandom_range(0, 1) ? '1 : '0;
    for (int i = 0; i <= BURST; i++) begin
      item.tag = TAG_W'($urandom_range(0, 31));
      case (shape)
        PAT_CLUSTER: item.conversion = base ^ SAMPLE_W'($urandom_range(0, 15));
        PAT_RISING:  item.conversion = base + SAMPLE_W'(i) * stride;
        PAT_FALLING: item.conversion = base - SAMPLE_W'(i) * stride;
        PAT_FLAT:    item.conversion = base;
        PAT_RAILS:   item.conversion = $urandom_range(0, 1) ? '1 : '0;
        PAT_REPEATS: begin
          case ($urandom_range(0, 3))
            0: item.conversion = base;
            1: item.conversion = base + 1'b1;
            2: item.conversion = '0;
            default: item.conversion = '1;
          endcase
        end
        default: item.conversion = SAMPLE_W'($urandom_range(0, 4095));
      endcase
      pending_items.push_back(item);
    end
  endtask

  task automatic queue_random_bursts(input int unsigned count);
    repeat (count) queue_burst(burst_shape_e'($urandom_range(PAT_RANDOM, PAT_REPEATS)));
  endtask

  // Hold until every item is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || stats_due.size() != 0);
  endtask

  // Sender
  always @(negedge clk_i) begin : sender
    adc_item_t item;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the stalled item
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          in_valid_i <= 1'b0;
          send_gap = $urandom_range(0, 11);
        end else begin
          item = pending_items.pop_front();
          in_valid_i    <= 1'b1;
          conversion_i  <= item.conversion;
          channel_tag_i <= item.tag;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_done && results_seen >= 8) begin
        long_done = 1'b1;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        out_stall_i <= 1'b1;
        long_left--;
      end else if (stall_gap > 0) begin
        out_stall_i <= 1'b1;
        stall_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_gap = $urandom_range(0, 11);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted items, check accepted results
  always @(posedge clk_i) begin : monitor
    burst_stats_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        fold_sample(conversion_i, channel_tag_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (stats_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with none expected: min %0d max %0d mean %0d mid %0d ch %0d",
                   $time, smallest_o, largest_o, average_o, middle_o, channel_out_o);
        end else begin
          want = stats_due.pop_front();
          check_field("smallest", want.smallest, smallest_o);
          check_field("largest", want.largest, largest_o);
          check_field("average", want.average, average_o);
          check_field("middle", want.middle, middle_o);
          check_field("channel_out", want.channel, channel_out_o);
        end
      end
    end
  end

  initial begin
    adc_item_t item;
    foreach (ranked[i]) ranked[i] = '0;
    sum_acc   = 0;
    taken_cnt = 0;
    burst_tag = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Strictly falling burst from full scale to zero: every insertion
    // shifts the whole filled part of the store
    item.conversion = '1;
    item.tag        = 5'd31;
    pending_items.push_back(item);
    for (int k = 0; k < BURST; k++) begin
      item.conversion = SAMPLE_W'(4095 - 273 * k);
      item.tag        = '0;
      pending_items.push_back(item);
    end
    wait_drained();

    queue_random_bursts(30);
    // sender pause: let every outstanding result come back
    wait_drained();

    queue_random_bursts(23);
    do @(negedge clk_i); while (pending_items.size() != 0);
    calm = 1'b1;
    queue_random_bursts(8);
    wait_drained();
    repeat (40) @(negedge clk_i);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bss_pkg.sv
hdl/bss_front.sv
hdl/bss_queue.sv
hdl/bss_back.sv
hdl/burst_sample_statistics_unit.sv
hdl/bss_checker.sv
bench/testbench.sv
